>>> design/spsm_pkg.sv
// ----------------------------------------------------------------------------
// spsm_pkg
// Shared types, codes and the control store of the sample-to-plot mapper.
// ----------------------------------------------------------------------------
package spsm_pkg;

  localparam int PLOT_WIDTH_DEF = 400;
  localparam int COL_W          = 11;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 56;
  localparam logic [31:0] HALF_Q32 = 32'h8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LEFT_X          = 3'd0,
    REG_BOTTOM_Y        = 3'd1,
    REG_TOP_Y           = 3'd2,
    REG_START_TIME      = 3'd3,
    REG_COLUMN_INTERVAL = 3'd4,
    REG_VALUE_OFFSET    = 3'd5,
    REG_PIXELS_PER_UNIT = 3'd6,
    REG_DRAW_MODE       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_SEG    = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EDGE   = 2'd2,
    ST_NOMODE = 2'd3
  } status_t;

  typedef struct packed {
    logic [11:0] left_x;
    logic [11:0] bottom_y;
    logic [11:0] top_y;
    logic [31:0] start_time;
    logic [19:0] column_interval;
    logic [31:0] value_offset;
    logic [31:0] pixels_per_unit;
    logic [2:0]  draw_mode;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [12:0]        seg_x1;
    logic [11:0]        seg_y1;
    logic [12:0]        seg_x2;
    logic signed [12:0] seg_y2;
  } result_t;

  // Sequencer steps
  typedef enum logic [2:0] {
    STEP_WAIT  = 3'd0,
    STEP_PREP  = 3'd1,
    STEP_MUL   = 3'd2,
    STEP_SCAN  = 3'd3,
    STEP_CHECK = 3'd4,
    STEP_EVAL  = 3'd5,
    STEP_EMIT  = 3'd6,
    STEP_EDGE  = 3'd7
  } step_t;

  // Datapath operations
  typedef enum logic [2:0] {
    ACT_LATCH = 3'd0,
    ACT_PREP  = 3'd1,
    ACT_MUL   = 3'd2,
    ACT_SCAN  = 3'd3,
    ACT_NONE  = 3'd4,
    ACT_EVAL  = 3'd5,
    ACT_EMIT  = 3'd6,
    ACT_EDGE  = 3'd7
  } act_t;

  // Branch and hold conditions
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_INPUT  = 3'd2,
    C_DONE      = 3'd3,
    C_SCAN_MORE = 3'd4,
    C_PAST_EDGE = 3'd5,
    C_OUT_BUSY  = 3'd6
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t hold;    // stay on this step while true
    cond_t jump;    // otherwise branch to target when true
    step_t target;
  } uword_t;

  typedef struct packed {
    act_t act;
    logic go;       // step completes this cycle
  } ctl_t;

  typedef struct packed {
    logic done;
    logic scan_more;
    logic past_edge;
  } dp_flags_t;

  // Control store: one word per step
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      STEP_WAIT:  w = '{ACT_LATCH, C_NO_INPUT,  C_NEVER,     STEP_WAIT};
      STEP_PREP:  w = '{ACT_PREP,  C_NEVER,     C_DONE,      STEP_EDGE};
      STEP_MUL:   w = '{ACT_MUL,   C_NEVER,     C_NEVER,     STEP_WAIT};
      STEP_SCAN:  w = '{ACT_SCAN,  C_SCAN_MORE, C_NEVER,     STEP_WAIT};
      STEP_CHECK: w = '{ACT_NONE,  C_NEVER,     C_PAST_EDGE, STEP_EDGE};
      STEP_EVAL:  w = '{ACT_EVAL,  C_NEVER,     C_NEVER,     STEP_WAIT};
      STEP_EMIT:  w = '{ACT_EMIT,  C_OUT_BUSY,  C_ALWAYS,    STEP_WAIT};
      STEP_EDGE:  w = '{ACT_EDGE,  C_OUT_BUSY,  C_ALWAYS,    STEP_WAIT};
      default:    w = '{ACT_NONE,  C_NEVER,     C_ALWAYS,    STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/spsm_seq.sv
// ----------------------------------------------------------------------------
// spsm_seq
// Step counter and control store readout with hold and branch conditions.
// ----------------------------------------------------------------------------
module spsm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_busy,
  input  spsm_pkg::dp_flags_t  flags,
  output logic                 in_ready,
  output spsm_pkg::ctl_t       ctl
);

  spsm_pkg::step_t  pc_r, pc_nxt;
  spsm_pkg::uword_t word;
  logic             hold, jump;

  function automatic logic cond_eval(input spsm_pkg::cond_t c, input logic iv,
                                     input logic ob, input spsm_pkg::dp_flags_t f);
    logic r;
    unique case (c)
      spsm_pkg::C_NEVER:     r = 1'b0;
      spsm_pkg::C_ALWAYS:    r = 1'b1;
      spsm_pkg::C_NO_INPUT:  r = !iv;
      spsm_pkg::C_DONE:      r = f.done;
      spsm_pkg::C_SCAN_MORE: r = f.scan_more;
      spsm_pkg::C_PAST_EDGE: r = f.past_edge;
      spsm_pkg::C_OUT_BUSY:  r = ob;
      default:               r = 1'b0;
    endcase
    return r;
  endfunction

  assign word = spsm_pkg::ucode(pc_r);
  assign hold = cond_eval(word.hold, in_valid, out_busy, flags);
  assign jump = cond_eval(word.jump, in_valid, out_busy, flags);

  // Next step
  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = spsm_pkg::step_t'(pc_r + 3'd1);
    end
  end

  // Outputs
  always_comb begin
    in_ready = (pc_r == spsm_pkg::STEP_WAIT);
    ctl.act  = word.act;
    ctl.go   = !hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= spsm_pkg::STEP_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> (pc_r == spsm_pkg::STEP_PREP))
    else $error("accepted item did not advance to prep step");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((pc_r == spsm_pkg::STEP_EMIT || pc_r == spsm_pkg::STEP_EDGE) && out_busy)
      |=> (pc_r == $past(pc_r)))
    else $error("result step left while output register busy");

endmodule

>>> design/spsm_dp.sv
// ----------------------------------------------------------------------------
// spsm_dp
// Datapath: column cursor, time and value arithmetic, previous point.
// ----------------------------------------------------------------------------
module spsm_dp #(
  parameter int PLOT_WIDTH = spsm_pkg::PLOT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spsm_pkg::ctl_t       ctl,
  input  spsm_pkg::cfg_t       cfg,
  input  logic                 in_new_series,
  input  logic [31:0]          in_time,
  input  logic [31:0]          in_value,
  output spsm_pkg::dp_flags_t  flags,
  output spsm_pkg::result_t    res,
  output logic                 res_load
);

  localparam logic [spsm_pkg::COL_W-1:0] PW = spsm_pkg::COL_W'(PLOT_WIDTH);

  logic [31:0]                time_r, time_nxt;
  logic [31:0]                value_r, value_nxt;
  logic [spsm_pkg::COL_W-1:0] col_r, col_nxt;
  logic                       done_r, done_nxt;
  logic                       pvalid_r, pvalid_nxt;
  logic [12:0]                px_r, px_nxt;
  logic [11:0]                py_r, py_nxt;
  logic [30:0]                prod_r, prod_nxt;
  logic [32:0]                diff_r, diff_nxt;
  logic [39:0]                ct_r, ct_nxt;
  logic [63:0]                p_r, p_nxt;
  logic                       bad_r, bad_nxt;
  logic [11:0]                rq_r, rq_nxt;

  logic [11:0] span;
  logic [43:0] rounded;
  logic [12:0] x_pix;
  logic [11:0] y_pix;
  logic [12:0] y_ext;
  logic        seg_ok;

  assign span    = cfg.bottom_y - cfg.top_y;
  assign rounded = {span, spsm_pkg::HALF_Q32} - p_r[43:0];
  assign x_pix   = {1'b0, cfg.left_x} + {2'b0, col_r};
  assign y_pix   = cfg.top_y + rq_r;
  assign y_ext   = {1'b0, y_pix};
  assign seg_ok  = !bad_r && (cfg.draw_mode[1:0] != 2'b00);

  always_comb begin
    flags.done      = done_r;
    flags.scan_more = (col_r < PW) && (ct_r < {8'b0, time_r});
    flags.past_edge = (col_r >= PW);
  end

  always_comb begin
    time_nxt   = time_r;
    value_nxt  = value_r;
    col_nxt    = col_r;
    done_nxt   = done_r;
    pvalid_nxt = pvalid_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    prod_nxt   = prod_r;
    diff_nxt   = diff_r;
    ct_nxt     = ct_r;
    p_nxt      = p_r;
    bad_nxt    = bad_r;
    rq_nxt     = rq_r;
    res        = '{spsm_pkg::ST_SEG, 13'd0, 12'd0, 13'd0, 13'sd0};
    res_load   = 1'b0;

    case (ctl.act)
      spsm_pkg::ACT_LATCH: begin
        if (ctl.go) begin
          time_nxt  = in_time;
          value_nxt = in_value;
          if (in_new_series) begin
            col_nxt    = '0;
            done_nxt   = 1'b0;
            pvalid_nxt = 1'b0;
            px_nxt     = '0;
            py_nxt     = '0;
          end
        end
      end
      spsm_pkg::ACT_PREP: begin
        prod_nxt = {20'b0, col_r} * {11'b0, cfg.column_interval};
        diff_nxt = {value_r[31], value_r} - {cfg.value_offset[31], cfg.value_offset};
      end
      spsm_pkg::ACT_MUL: begin
        ct_nxt = {8'b0, cfg.start_time} + {9'b0, prod_r};
        p_nxt  = {32'b0, diff_r[31:0]} * {32'b0, cfg.pixels_per_unit};
      end
      spsm_pkg::ACT_SCAN: begin
        // advance one column per cycle while held
        if (!ctl.go) begin
          col_nxt = col_r + spsm_pkg::COL_W'(1);
          ct_nxt  = ct_r + {20'b0, cfg.column_interval};
        end
      end
      spsm_pkg::ACT_EVAL: begin
        bad_nxt = diff_r[32] || (cfg.top_y > cfg.bottom_y)
                  || (p_r > {20'b0, span, 32'b0});
        rq_nxt  = rounded[43:32];
      end
      spsm_pkg::ACT_EMIT: begin
        res_load = ctl.go;
        if (bad_r) begin
          res.status = spsm_pkg::ST_RANGE;
        end else if (cfg.draw_mode[1:0] == 2'b00) begin
          res.status = spsm_pkg::ST_NOMODE;
        end else if (cfg.draw_mode[1]) begin
          res.seg_x1 = x_pix;
          res.seg_y1 = cfg.bottom_y;
          res.seg_x2 = x_pix;
          res.seg_y2 = cfg.draw_mode[2] ? y_ext - 13'd1 : y_ext;
        end else begin
          res.seg_x1 = pvalid_r ? px_r : x_pix;
          res.seg_y1 = pvalid_r ? py_r : y_pix;
          res.seg_x2 = x_pix;
          res.seg_y2 = y_ext;
        end
        if (ctl.go) begin
          col_nxt = col_r + spsm_pkg::COL_W'(1);
          if (seg_ok && cfg.draw_mode[0]) begin
            pvalid_nxt = 1'b1;
            px_nxt     = x_pix;
            py_nxt     = y_pix;
          end
        end
      end
      spsm_pkg::ACT_EDGE: begin
        res.status = spsm_pkg::ST_EDGE;
        res_load   = ctl.go;
        if (ctl.go) begin
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      done_r   <= 1'b0;
      pvalid_r <= 1'b0;
      px_r     <= '0;
      py_r     <= '0;
    end else begin
      col_r    <= col_nxt;
      done_r   <= done_nxt;
      pvalid_r <= pvalid_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r  <= time_nxt;
    value_r <= value_nxt;
    prod_r  <= prod_nxt;
    diff_r  <= diff_nxt;
    ct_r    <= ct_nxt;
    p_r     <= p_nxt;
    bad_r   <= bad_nxt;
    rq_r    <= rq_nxt;
  end

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= PW)
    else $error("column cursor beyond plot width");

endmodule

>>> design/sample_to_plot_segment_mapper_core.sv
// ----------------------------------------------------------------------------
// sample_to_plot_segment_mapper_core
// Steps: an accepted item is latched; the column time and the value offset
//   difference are prepared and multiplied; the cursor then skips columns, one
//   per cycle in the scan step, until the column time reaches the sample time
//   or the right edge; the edge is checked, the pixel evaluated and the result
//   emitted. Off the right edge, or for a finished series, an edge status is emitted.
// The single-step sequencer takes one item at a time; the next item is taken
//   while a result waits, but an emit step holds while that result is pending.
// Reset: rst_n synchronous, active low; clears cursor, previous point, the
//   output valid flag and loads configuration defaults.
// ----------------------------------------------------------------------------
module sample_to_plot_segment_mapper_core #(
  parameter int PLOT_WIDTH = spsm_pkg::PLOT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spsm_pkg::IN_TDATA_W-1:0]     in_tdata,   // sample_time, sample_value
  input  logic                                in_tuser,   // new_series
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spsm_pkg::OUT_TDATA_W-1:0]    out_tdata,  // seg_x1, seg_y1, seg_x2, seg_y2
  output logic [1:0]                          out_tuser,  // status
  // configuration writes
  input  logic                                cfg_we,
  input  logic [spsm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [spsm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  spsm_pkg::cfg_t      cfg_r, cfg_nxt;
  spsm_pkg::ctl_t      ctl;
  spsm_pkg::dp_flags_t flags;
  spsm_pkg::result_t   res, out_res_r;
  logic                res_load;
  logic                out_valid_r;
  logic                out_busy;

  // --------------------------------------------------------------------------
  // Configuration bank: write one register per transfer, masked to its width.
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (spsm_pkg::reg_idx_t'(cfg_addr))
        spsm_pkg::REG_LEFT_X:          cfg_nxt.left_x          = cfg_wdata[11:0];
        spsm_pkg::REG_BOTTOM_Y:        cfg_nxt.bottom_y        = cfg_wdata[11:0];
        spsm_pkg::REG_TOP_Y:           cfg_nxt.top_y           = cfg_wdata[11:0];
        spsm_pkg::REG_START_TIME:      cfg_nxt.start_time      = cfg_wdata;
        spsm_pkg::REG_COLUMN_INTERVAL: cfg_nxt.column_interval = cfg_wdata[19:0];
        spsm_pkg::REG_VALUE_OFFSET:    cfg_nxt.value_offset    = cfg_wdata;
        spsm_pkg::REG_PIXELS_PER_UNIT: cfg_nxt.pixels_per_unit = cfg_wdata;
        spsm_pkg::REG_DRAW_MODE:       cfg_nxt.draw_mode       = cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_x          <= 12'd0;
      cfg_r.bottom_y        <= 12'd0;
      cfg_r.top_y           <= 12'd0;
      cfg_r.start_time      <= 32'd0;
      cfg_r.column_interval <= 20'd300;
      cfg_r.value_offset    <= 32'd0;
      cfg_r.pixels_per_unit <= 32'd65536;
      cfg_r.draw_mode       <= 3'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer walks the control store; the datapath executes each word.
  // --------------------------------------------------------------------------
  assign out_busy = out_valid_r && !out_tready;

  spsm_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_busy (out_busy),
    .flags    (flags),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  spsm_dp #(
    .PLOT_WIDTH (PLOT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cfg           (cfg_r),
    .in_new_series (in_tuser),
    .in_time       (in_tdata[31:0]),
    .in_value      (in_tdata[63:32]),
    .flags         (flags),
    .res           (res),
    .res_load      (res_load)
  );

  // --------------------------------------------------------------------------
  // Output register: hold the result until the transfer, so the sequencer
  // can go back and take the next item meanwhile.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'b0, out_res_r.seg_y2, out_res_r.seg_x2,
                       out_res_r.seg_y1, out_res_r.seg_x1};

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_busy)
    else $error("result loaded over a pending transfer");

  a_zero_unless_seg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != spsm_pkg::ST_SEG) |-> (out_tdata == '0))
    else $error("non-segment result carries coordinates");

endmodule
